### rtl/md5sh_pkg.sv
// ----------------------------------------------------------------------------
// md5sh_pkg
// shared constants, types and round tables for the md5 stream hasher
// ----------------------------------------------------------------------------
package md5sh_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // request passed from the front part to the back part
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } md5sh_req_t;

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word used by round i
    function automatic logic [3:0] msg_idx(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0:    g = i[3:0];
            2'd1:    g = 4'(5 * i + 1);
            2'd2:    g = 4'(3 * i + 5);
            default: g = 4'(7 * i);
        endcase
        return g;
    endfunction

endpackage

### rtl/md5_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// md5_stream_hasher_unit
// streaming md5 digest engine with queue-style ports
// ----------------------------------------------------------------------------
// Bytes enter through a small request queue and are packed into a 64-byte
// block one per cycle while the core loads. Each full block runs through
// the single-round compression unit, then folds into the chaining words;
// no bytes are taken meanwhile. An end of message adds padding (marker
// byte, zero bytes and the length) and one or two blocks, then the four
// digest words are offered in order, word 0 first.
module md5_stream_hasher_unit #(
    parameter int QUEUE_DEPTH = md5sh_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  message_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);
    md5sh_pkg::md5sh_req_t req;
    logic req_valid, req_take;

    md5sh_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk, .rst_n, .push, .full, .message_byte, .byte_present,
        .end_of_message, .req, .req_valid, .req_take
    );

    md5sh_core u_core (
        .clk, .rst_n, .req, .req_valid, .req_take, .empty, .pop,
        .digest_word, .word_index, .last_word
    );
endmodule

### rtl/md5sh_front.sv
// ----------------------------------------------------------------------------
// md5sh_front
// input side: drops idle items and queues requests for the core
// ----------------------------------------------------------------------------
module md5sh_front #(
    parameter int DEPTH = md5sh_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             message_byte,
    input  logic                   byte_present,
    input  logic                   end_of_message,
    output md5sh_pkg::md5sh_req_t  req,
    output logic                   req_valid,
    input  logic                   req_take
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    md5sh_pkg::md5sh_req_t q_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          wr_en, rd_en;

    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign req_valid = (cnt_reg != '0);
    assign req       = q_reg[rd_reg];
    // idle items have no effect and are not queued
    assign wr_en = push && !full && (byte_present || end_of_message);
    assign rd_en = req_valid && req_take;

    always_comb
    begin
        wr_next  = wr_en ? ((wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = rd_en ? ((rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_reg[wr_reg] <= '{data: message_byte, present: byte_present,
                               last: end_of_message};
    end
endmodule

### rtl/md5sh_core.sv
// ----------------------------------------------------------------------------
// md5sh_core
// back part: byte packing, padding, one md5 round per cycle, digest output
// ----------------------------------------------------------------------------
module md5sh_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  md5sh_pkg::md5sh_req_t  req,
    input  logic                   req_valid,
    output logic                   req_take,
    output logic                   empty,
    input  logic                   pop,
    output logic [31:0]            digest_word,
    output logic [1:0]             word_index,
    output logic                   last_word
);
    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LEN   = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [31:0]   blk_reg [16];
    logic [31:0]   h_reg [4];
    logic [31:0]   a_reg, b_reg, c_reg, d_reg;
    logic [5:0]    pos_reg, pos_next;
    logic [60:0]   total_reg, total_next;
    logic [5:0]    rnd_reg;
    logic          fin_reg, fin_next;     // block in the rounds is the last one
    logic          pad_reg, pad_next;     // padding goes on after this block
    logic          mark_reg, mark_next;   // marker byte already written
    logic [1:0]    oidx_reg;

    logic          wr_byte;
    logic [7:0]    wr_val;
    logic [63:0]   bits;
    logic [31:0]   f, sum, rot, new_b;
    logic [4:0]    s;

    assign req_take = (state_reg == S_LOAD) && req_valid;
    assign bits     = {total_reg, 3'b000};
    assign empty    = (state_reg != S_OUT);
    assign digest_word = h_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 2'd3);

    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum   = a_reg + f + md5sh_pkg::sine_k(rnd_reg)
                + blk_reg[md5sh_pkg::msg_idx(rnd_reg)];
        s     = md5sh_pkg::rot_s(rnd_reg);
        rot   = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
        new_b = b_reg + rot;
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        fin_next   = fin_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        wr_byte    = 1'b0;
        wr_val     = '0;
        case (state_reg)
            S_LOAD:
            begin
                if (req_valid)
                begin
                    if (req.present)
                    begin
                        wr_byte    = 1'b1;
                        wr_val     = req.data;
                        pos_next   = pos_reg + 1'b1;
                        total_next = total_reg + 1'b1;
                        if (pos_reg == 6'd63)
                        begin
                            state_next = S_ROUND;
                            pad_next   = req.last;
                        end
                        else if (req.last)
                            state_next = S_PAD;
                    end
                    else
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                // marker byte, then zeros
                wr_byte   = 1'b1;
                wr_val    = (mark_reg) ? 8'h00 : md5sh_pkg::PAD_BYTE;
                mark_next = 1'b1;
                pos_next  = pos_reg + 1'b1;
                if (pos_reg == 6'd63)
                begin
                    state_next = S_ROUND;
                    pad_next   = 1'b1;
                end
                else if (pos_next == md5sh_pkg::LEN_POS)
                    state_next = S_LEN;
            end
            S_LEN:
            begin
                fin_next   = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
                if (rnd_reg == 6'd63)
                    state_next = S_ADD;
            S_ADD:
            begin
                if (fin_reg)
                    state_next = S_OUT;
                else if (pad_reg)
                begin
                    state_next = S_PAD;
                    pad_next   = 1'b0;
                end
                else
                    state_next = S_LOAD;
            end
            S_OUT:
                if (pop && oidx_reg == 2'd3)
                begin
                    state_next = S_LOAD;
                    fin_next   = 1'b0;
                    mark_next  = 1'b0;
                    total_next = '0;
                    pos_next   = '0;
                end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            pos_reg   <= '0;
            total_reg <= '0;
            fin_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            rnd_reg   <= '0;
            oidx_reg  <= '0;
            h_reg[0]  <= md5sh_pkg::INIT_A;
            h_reg[1]  <= md5sh_pkg::INIT_B;
            h_reg[2]  <= md5sh_pkg::INIT_C;
            h_reg[3]  <= md5sh_pkg::INIT_D;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            fin_reg   <= fin_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            if (state_reg == S_ROUND)
                rnd_reg <= rnd_reg + 1'b1;
            if (state_reg == S_ADD)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
            end
            if (state_reg == S_OUT && pop)
            begin
                oidx_reg <= oidx_reg + 1'b1;
                if (oidx_reg == 2'd3)
                begin
                    h_reg[0] <= md5sh_pkg::INIT_A;
                    h_reg[1] <= md5sh_pkg::INIT_B;
                    h_reg[2] <= md5sh_pkg::INIT_C;
                    h_reg[3] <= md5sh_pkg::INIT_D;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_byte)
        begin
            case (pos_reg[1:0])
                2'd0:    blk_reg[pos_reg[5:2]] <= {24'h0, wr_val};
                2'd1:    blk_reg[pos_reg[5:2]][15:8]  <= wr_val;
                2'd2:    blk_reg[pos_reg[5:2]][23:16] <= wr_val;
                default: blk_reg[pos_reg[5:2]][31:24] <= wr_val;
            endcase
        end
        if (state_reg == S_LEN)
        begin
            blk_reg[14] <= bits[31:0];
            blk_reg[15] <= bits[63:32];
        end
        if (state_next == S_ROUND && state_reg != S_ROUND)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
        end
        else if (state_reg == S_ROUND)
        begin
            a_reg <= d_reg;
            b_reg <= new_b;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end
endmodule

### rtl/md5sh_checker.sv
// ----------------------------------------------------------------------------
// md5sh_checker
// port-level checks for the md5 stream hasher
// ----------------------------------------------------------------------------
module md5sh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  word_index,
    input logic        last_word,
    input logic [31:0] digest_word
);
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_word == (word_index == 2'd3)))
        else $error("last_word mismatch");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && word_index != 2'd3) |=> (!empty
            && word_index == $past(word_index) + 2'd1))
        else $error("digest words out of order");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digest_word)))
        else $error("result changed while waiting");
endmodule

bind md5_stream_hasher_unit md5sh_checker u_checker (
    .clk, .rst_n, .empty, .pop, .word_index, .last_word, .digest_word
);
